// File: sv/sacfm_pkg.sv
`default_nettype none

package sacfm_pkg;

  // Sample format: Q1.F two's complement, F = SAMPLE_WIDTH - 2
  localparam int SAMPLE_WIDTH = 24;
  localparam int FRAC_W       = SAMPLE_WIDTH - 2;

  // Q1.22 operands (coefficients, position, wet share, smoother gains)
  localparam int QF     = 22;
  localparam int Q_W    = 24;
  localparam int HIST_W = 32;

  // Datapath widths: value operand, product, sum of two products, rounded result
  localparam int DW = ((SAMPLE_WIDTH > HIST_W) ? SAMPLE_WIDTH : HIST_W) + 2;
  localparam int PW = DW + Q_W;
  localparam int AW = PW + 1;
  localparam int RW = AW - QF;

  localparam logic signed [AW-1:0] RND_HALF = AW'(64'sd1 << (QF - 1));

  localparam logic signed [Q_W-1:0] Q_ONE     = Q_W'(4194304);
  localparam logic signed [Q_W-1:0] Q_NEG_ONE = Q_W'(-4194304);
  localparam logic signed [Q_W-1:0] K_POS     = Q_W'(20972);
  localparam logic signed [Q_W-1:0] K_COEF    = Q_W'(4194);
  localparam logic signed [Q_W-1:0] K_WET     = Q_W'(209715);
  localparam logic signed [Q_W-1:0] K_DECAY   = Q_W'(4152361);
  localparam logic signed [Q_W-1:0] BYPASS_LIM     = Q_W'(20972);
  localparam logic signed [Q_W-1:0] BYPASS_LIM_NEG = Q_W'(-20972);
  localparam logic signed [Q_W-1:0] WET_SMOOTH_RST = Q_W'(2097152);

  // Register reset values
  localparam logic [22:0] LPC_TGT_RST  = 23'(3116000);
  localparam logic [22:0] HPC_TGT_RST  = 23'(-4181140);
  localparam logic [23:0] POSITION_RST = 24'd0;
  localparam logic [22:0] WET_AMT_RST  = 23'(4194304);

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LPC_TGT  = 2'd0,
    CFG_HPC_TGT  = 2'd1,
    CFG_POSITION = 2'd2,
    CFG_WET_AMT  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] wet_left;
    logic signed [SAMPLE_WIDTH-1:0] wet_right;
    logic                           wet_present;
    logic signed [SAMPLE_WIDTH-1:0] dry_left;
    logic signed [SAMPLE_WIDTH-1:0] dry_right;
    logic                           clear_history;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] out_left;
    logic signed [SAMPLE_WIDTH-1:0] out_right;
  } out_item_t;

  // Sequencer steps; each multiply step but ST_M1 issues a product and then writes it back
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POS,
    ST_WET,
    ST_LPC,
    ST_HPC,
    ST_LA1,
    ST_LA2,
    ST_HA1,
    ST_HA2,
    ST_DL,
    ST_DH,
    ST_M1,
    ST_M2,
    ST_OUT
  } seq_state_t;

  typedef struct packed {
    logic issue;
    logic acc_ld;
    logic use_acc;
  } mac_ctl_t;

  typedef struct packed {
    seq_state_t state;
    logic       wb;
    logic       ch;
    logic       accept;
    logic       out_load;
  } seq_ctl_t;

endpackage

`default_nettype wire

// File: sv/sacfm_mac.sv
`default_nettype none

module sacfm_mac import sacfm_pkg::*; (
  input  logic                  clk,
  input  mac_ctl_t              ctl,
  input  logic signed [DW-1:0]  a,
  input  logic signed [Q_W-1:0] b,
  output logic signed [RW-1:0]  rnd
);

  logic signed [PW-1:0] prod_r;
  logic signed [PW-1:0] acc_r;
  logic signed [AW-1:0] sum;

  // registered product; the previous product can be parked for a two-term sum
  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      prod_r <= a * b;
    end
    if (ctl.acc_ld) begin
      acc_r <= prod_r;
    end
  end

  // round to nearest Q1.22 step, ties toward plus infinity
  assign sum = (ctl.use_acc ? AW'(acc_r) : AW'(0)) + AW'(prod_r) + RND_HALF;
  assign rnd = RW'(sum >>> QF);

endmodule

`default_nettype wire

// File: sv/sacfm_ctrl.sv
`default_nettype none

module sacfm_ctrl import sacfm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     out_free,
  input  logic     bypass,
  output logic     in_ready,
  output seq_ctl_t seq,
  output mac_ctl_t mac
);

  seq_state_t state_r, state_nxt;
  seq_state_t succ;
  logic       wb_r, wb_nxt;
  logic       ch_r, ch_nxt;
  logic       accept;
  logic       out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      wb_r    <= 1'b0;
      ch_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wb_r    <= wb_nxt;
      ch_r    <= ch_nxt;
    end
  end

  // step that follows a finished issue/writeback pair
  always_comb begin
    case (state_r)
      ST_POS:  succ = ST_WET;
      ST_WET:  succ = ST_LPC;
      ST_LPC:  succ = ST_HPC;
      ST_HPC:  succ = ST_LA1;
      ST_LA1:  succ = ST_LA2;
      ST_LA2:  succ = ST_HA1;
      ST_HA1:  succ = ST_HA2;
      ST_HA2:  succ = bypass ? ST_DL : ST_M1;
      ST_DL:   succ = ST_DH;
      ST_DH:   succ = ST_M1;
      default: succ = ST_IDLE;
    endcase
  end

  // next state and control outputs
  always_comb begin
    state_nxt = state_r;
    wb_nxt    = wb_r;
    ch_nxt    = ch_r;
    in_ready  = 1'b0;
    accept    = 1'b0;
    out_load  = 1'b0;
    mac       = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          accept    = 1'b1;
          state_nxt = ST_POS;
          wb_nxt    = 1'b0;
          ch_nxt    = 1'b0;
        end
      end
      ST_POS, ST_WET, ST_LPC, ST_HPC, ST_LA1, ST_LA2, ST_HA1, ST_HA2, ST_DL, ST_DH: begin
        if (!wb_r) begin
          mac.issue = 1'b1;
          wb_nxt    = 1'b1;
        end else begin
          wb_nxt    = 1'b0;
          state_nxt = succ;
        end
      end
      // first mix term: product only, summed during the next step
      ST_M1: begin
        mac.issue = 1'b1;
        state_nxt = ST_M2;
      end
      ST_M2: begin
        if (!wb_r) begin
          mac.issue  = 1'b1;
          mac.acc_ld = 1'b1;
          wb_nxt     = 1'b1;
        end else begin
          mac.use_acc = 1'b1;
          wb_nxt      = 1'b0;
          if (ch_r) begin
            state_nxt = ST_OUT;
          end else begin
            ch_nxt    = 1'b1;
            state_nxt = ST_LA1;
          end
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        wb_nxt    = 1'b0;
      end
    endcase
  end

  assign seq.state    = state_r;
  assign seq.wb       = wb_r;
  assign seq.ch       = ch_r;
  assign seq.accept   = accept;
  assign seq.out_load = out_load;

endmodule

`default_nettype wire

// File: sv/stereo_allpass_crossfade_filter_mix.sv
// Requests are taken one at a time: in_ready is high only while the sequencer is
// idle, and a finished result waits until the output register is free. When the
// smoothed position sits in the center bypass band, the allpass states decay in
// extra steps. Every product goes through one shared 34x24 multiplier.
// Reset (synchronous, rst_n low): sequencer idle, output empty, registers at
// their defaults, smoothers, held wet pair and allpass states at reset values.
`default_nettype none

module stereo_allpass_crossfade_filter_mix import sacfm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [Q_W-1:0]       cfg_data
);

  localparam logic signed [RW:0] H_MAX = (RW+1)'(64'sd2147483647);
  localparam logic signed [RW:0] H_MIN = (RW+1)'(-64'sd2147483648);
  localparam logic signed [RW-1:0] MIX_MAX = RW'(64'sd1 << FRAC_W);
  localparam logic signed [RW-1:0] MIX_MIN = RW'(-(64'sd1 << FRAC_W));

  function automatic logic signed [HIST_W-1:0] sat_hist(input logic signed [RW:0] v);
    logic signed [HIST_W-1:0] res;
    if (v > H_MAX) begin
      res = HIST_W'(H_MAX);
    end else if (v < H_MIN) begin
      res = HIST_W'(H_MIN);
    end else begin
      res = HIST_W'(v);
    end
    return res;
  endfunction

  // configuration
  logic signed [22:0] lpc_tgt_r;
  logic signed [22:0] hpc_tgt_r;
  logic signed [23:0] pos_tgt_r;
  logic        [22:0] wet_amt_r;

  // filter state
  logic signed [Q_W-1:0]          pos_s_r, lpc_s_r, hpc_s_r, wet_s_r;
  logic signed [SAMPLE_WIDTH-1:0] held_r [2];
  logic signed [HIST_W-1:0]       hist_r [4];

  // per-request working registers
  logic signed [SAMPLE_WIDTH-1:0] dry_r [2];
  logic signed [SAMPLE_WIDTH-1:0] res_r [2];
  logic signed [HIST_W-1:0]       old_h_r;
  logic signed [DW-1:0]           xv_r;
  out_item_t                      out_data_r;
  logic                           out_valid_r;

  seq_ctl_t seq;
  mac_ctl_t mac_ctl;
  logic     bypass;
  logic     out_free;

  logic signed [DW-1:0]           op_a;
  logic signed [Q_W-1:0]          op_b;
  logic signed [RW-1:0]           rnd;
  logic signed [Q_W-1:0]          lp_t, hp_t, pos_t, wet_t;
  logic signed [Q_W-1:0]          sm_t, sm_s;
  logic signed [Q_W:0]            sm_d;
  logic                           hp_sel;
  logic [1:0]                     hidx;
  logic signed [HIST_W-1:0]       hist_rd;
  logic signed [SAMPLE_WIDTH-1:0] wet_ch, dry_ch;
  logic signed [RW:0]             nh_in, ap_sum;
  logic signed [RW+1:0]           half_in, half_out;
  logic signed [SAMPLE_WIDTH-1:0] mix_sat;

  sacfm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .bypass   (bypass),
    .in_ready (in_ready),
    .seq      (seq),
    .mac      (mac_ctl)
  );

  sacfm_mac u_mac (
    .clk (clk),
    .ctl (mac_ctl),
    .a   (op_a),
    .b   (op_b),
    .rnd (rnd)
  );

  // targets, with position and wet share clamped to their legal range
  always_comb begin
    lp_t = {{(Q_W-23){lpc_tgt_r[22]}}, lpc_tgt_r};
    hp_t = {{(Q_W-23){hpc_tgt_r[22]}}, hpc_tgt_r};
    if (pos_tgt_r > Q_ONE) begin
      pos_t = Q_ONE;
    end else if (pos_tgt_r < Q_NEG_ONE) begin
      pos_t = Q_NEG_ONE;
    end else begin
      pos_t = pos_tgt_r;
    end
    if ({1'b0, wet_amt_r} > Q_ONE) begin
      wet_t = Q_ONE;
    end else begin
      wet_t = {1'b0, wet_amt_r};
    end
  end

  assign bypass = (pos_s_r < BYPASS_LIM) && (pos_s_r > BYPASS_LIM_NEG);
  assign out_free = !out_valid_r || out_ready;

  // operand selection for the shared multiplier
  assign hp_sel = (seq.state == ST_HA1) || (seq.state == ST_HA2) || (seq.state == ST_DH);
  assign hidx    = {hp_sel, seq.ch};
  assign hist_rd = hist_r[hidx];
  assign wet_ch  = held_r[seq.ch];
  assign dry_ch  = dry_r[seq.ch];

  always_comb begin
    case (seq.state)
      ST_WET: begin
        sm_t = wet_t;
        sm_s = wet_s_r;
      end
      ST_LPC: begin
        sm_t = lp_t;
        sm_s = lpc_s_r;
      end
      ST_HPC: begin
        sm_t = hp_t;
        sm_s = hpc_s_r;
      end
      default: begin
        sm_t = pos_t;
        sm_s = pos_s_r;
      end
    endcase
    sm_d = {sm_t[Q_W-1], sm_t} - {sm_s[Q_W-1], sm_s};
  end

  always_comb begin
    case (seq.state)
      ST_POS: begin
        op_a = DW'(sm_d);
        op_b = K_POS;
      end
      ST_WET: begin
        op_a = DW'(sm_d);
        op_b = K_WET;
      end
      ST_LPC, ST_HPC: begin
        op_a = DW'(sm_d);
        op_b = K_COEF;
      end
      ST_LA1, ST_LA2: begin
        op_a = DW'(hist_rd);
        op_b = lpc_s_r;
      end
      ST_HA1, ST_HA2: begin
        op_a = DW'(hist_rd);
        op_b = hpc_s_r;
      end
      ST_DL, ST_DH: begin
        op_a = DW'(hist_rd);
        op_b = K_DECAY;
      end
      ST_M1: begin
        op_a = xv_r;
        op_b = wet_s_r;
      end
      ST_M2: begin
        op_a = DW'(dry_ch);
        op_b = Q_ONE - wet_s_r;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // writeback arithmetic
  always_comb begin
    if (seq.state == ST_LA1) begin
      nh_in = (RW+1)'(wet_ch) - (RW+1)'(rnd);
    end else begin
      nh_in = (RW+1)'(xv_r) - (RW+1)'(rnd);
    end
    ap_sum = (RW+1)'(rnd) + (RW+1)'(old_h_r);
    if (seq.state == ST_LA2) begin
      half_in = (RW+2)'(wet_ch) + (RW+2)'(ap_sum) + (RW+2)'(1);
    end else begin
      half_in = (RW+2)'(xv_r) - (RW+2)'(ap_sum) + (RW+2)'(1);
    end
    half_out = half_in >>> 1;
    if (rnd > MIX_MAX) begin
      mix_sat = SAMPLE_WIDTH'(MIX_MAX);
    end else if (rnd < MIX_MIN) begin
      mix_sat = SAMPLE_WIDTH'(MIX_MIN);
    end else begin
      mix_sat = SAMPLE_WIDTH'(rnd);
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lpc_tgt_r <= LPC_TGT_RST;
      hpc_tgt_r <= HPC_TGT_RST;
      pos_tgt_r <= POSITION_RST;
      wet_amt_r <= WET_AMT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LPC_TGT:  lpc_tgt_r <= cfg_data[22:0];
        CFG_HPC_TGT:  hpc_tgt_r <= cfg_data[22:0];
        CFG_POSITION: pos_tgt_r <= cfg_data[23:0];
        CFG_WET_AMT:  wet_amt_r <= cfg_data[22:0];
        default: ;
      endcase
    end
  end

  // smoothers, held wet pair and allpass states
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_s_r   <= '0;
      lpc_s_r   <= '0;
      hpc_s_r   <= '0;
      wet_s_r   <= WET_SMOOTH_RST;
      held_r[0] <= '0;
      held_r[1] <= '0;
      for (int i = 0; i < 4; i++) begin
        hist_r[i] <= '0;
      end
    end else if (seq.accept) begin
      if (in_data.clear_history) begin
        for (int i = 0; i < 4; i++) begin
          hist_r[i] <= '0;
        end
      end
      if (in_data.wet_present) begin
        held_r[0] <= in_data.wet_left;
        held_r[1] <= in_data.wet_right;
      end else if (in_data.clear_history) begin
        held_r[0] <= '0;
        held_r[1] <= '0;
      end
    end else if (seq.wb) begin
      case (seq.state)
        ST_POS: pos_s_r <= pos_s_r + Q_W'(rnd);
        ST_WET: wet_s_r <= wet_s_r + Q_W'(rnd);
        ST_LPC: lpc_s_r <= lpc_s_r + Q_W'(rnd);
        ST_HPC: hpc_s_r <= hpc_s_r + Q_W'(rnd);
        ST_LA1, ST_HA1: hist_r[hidx] <= sat_hist(nh_in);
        ST_DL, ST_DH: hist_r[hidx] <= sat_hist((RW+1)'(rnd));
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (seq.accept) begin
      dry_r[0] <= in_data.dry_left;
      dry_r[1] <= in_data.dry_right;
    end
    if (seq.wb) begin
      case (seq.state)
        ST_LA1, ST_HA1: old_h_r <= hist_rd;
        ST_LA2: xv_r <= DW'(half_out);
        ST_HA2: xv_r <= bypass ? DW'(wet_ch) : DW'(half_out);
        ST_M2: res_r[seq.ch] <= mix_sat;
        default: ;
      endcase
    end
    if (seq.out_load) begin
      out_data_r.out_left  <= res_r[0];
      out_data_r.out_right <= res_r[1];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= seq.out_load || (out_valid_r && !out_ready);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: sv/sacfm_checker.sv
`default_nettype none

module sacfm_checker import sacfm_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  localparam logic signed [SAMPLE_WIDTH-1:0] O_LIM     = SAMPLE_WIDTH'(64'sd1 << FRAC_W);
  localparam logic signed [SAMPLE_WIDTH-1:0] O_LIM_NEG = SAMPLE_WIDTH'(-(64'sd1 << FRAC_W));

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // a request keeps the block busy at least into the next cycle
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready stayed high after an accepted request");

  // a result only appears at the end of processing, never from idle
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while the block was idle");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // mixed output stays within plus or minus one
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.out_left <= O_LIM) && (out_data.out_left >= O_LIM_NEG) &&
                  (out_data.out_right <= O_LIM) && (out_data.out_right >= O_LIM_NEG))
    else $error("output outside clamp range");

endmodule

bind stereo_allpass_crossfade_filter_mix sacfm_checker u_sacfm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// File: sim/stereo_allpass_crossfade_filter_mix_tb.sv
`default_nettype none

module stereo_allpass_crossfade_filter_mix_tb;
  import sacfm_pkg::*;

  localparam int CYC_LIMIT = 4_000_000;
  localparam int RAND_REQS = 950;
  localparam int SOAK_REQS = 250;
  localparam int SWING_REQS = 100;

  localparam logic [23:0] S_MAX = 24'h7FFFFF;
  localparam logic [23:0] S_MIN = 24'h800000;
  localparam logic [23:0] P_ONE = 24'h400000;
  localparam logic [23:0] N_ONE = 24'hC00000;

  localparam longint L_ONE    = Q_ONE;
  localparam longint L_KPOS   = K_POS;
  localparam longint L_KCOEF  = K_COEF;
  localparam longint L_KWET   = K_WET;
  localparam longint L_DECAY  = K_DECAY;
  localparam longint L_BYPASS = BYPASS_LIM;
  localparam longint L_WETRST = WET_SMOOTH_RST;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [Q_W-1:0]       cfg_data;

  stereo_allpass_crossfade_filter_mix u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow of the block's state and registers
  longint      pos_sm;
  longint      lpc_sm;
  longint      hpc_sm;
  longint      wet_sm;
  longint      held_wet [2];
  longint      ap_hist [4];
  logic [23:0] tgt_reg [4];

  // Mix results waiting for the output channel
  out_item_t   mix_pending [$];
  out_item_t   head_mix;
  int          req_taken;
  bit          req_typed;
  out_item_t   req_want;
  int          fails;
  int          cyc_count;
  int          burst_left;

  // Directed stimulus rows: either a register write or a request
  typedef struct {
    bit          is_wr;
    cfg_idx_t    idx;
    logic [23:0] val;
    in_item_t    req;
    bit          typed;
    out_item_t   want;
  } dir_row_t;

  dir_row_t dir_rows [$];

  // floor((x + 2^(s-1)) / 2^s)
  function automatic longint rnd_shr(longint x, int s);
    return (x + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint qmul(longint a, longint c);
    return rnd_shr(a * c, QF);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint sat_hist(longint v);
    return clip(v, -64'sd2147483648, 64'sd2147483647);
  endfunction

  // First-order allpass section on history entry idx
  function automatic longint allpass_stage(longint x, longint c, int idx);
    longint nh;
    longint y;
    nh = sat_hist(x - qmul(c, ap_hist[idx]));
    y = qmul(c, nh) + ap_hist[idx];
    ap_hist[idx] = nh;
    return y;
  endfunction

  // LP then HP cascade, center bypass with decay, wet/dry mix and clamp
  function automatic longint filter_channel(longint wet, longint dry, int lp_i, int hp_i,
                                            bit bypass);
    longint lp;
    longint filt;
    longint mix;
    longint one;
    one = longint'(1) <<< FRAC_W;
    lp = rnd_shr(wet + allpass_stage(wet, lpc_sm, lp_i), 1);
    filt = rnd_shr(lp - allpass_stage(lp, hpc_sm, hp_i), 1);
    if (bypass) begin
      filt = wet;
      ap_hist[lp_i] = sat_hist(qmul(ap_hist[lp_i], L_DECAY));
      ap_hist[hp_i] = sat_hist(qmul(ap_hist[hp_i], L_DECAY));
    end
    mix = rnd_shr(filt * wet_sm + dry * (L_ONE - wet_sm), QF);
    return clip(mix, -one, one);
  endfunction

  // One stereo step: advances the shadow state, returns the mixed pair
  function automatic out_item_t compute_mix(in_item_t it);
    longint            wl;
    longint            wr;
    longint            dl;
    longint            dr;
    longint            lp_t;
    longint            hp_t;
    longint            pos_t;
    longint            wet_t;
    logic signed [22:0] c23;
    logic signed [23:0] c24;
    bit                bypass;
    longint            ol;
    longint            orr;
    out_item_t         r;
    wl = $signed(it.wet_left);
    wr = $signed(it.wet_right);
    dl = $signed(it.dry_left);
    dr = $signed(it.dry_right);
    if (it.clear_history) begin
      for (int i = 0; i < 4; i++) ap_hist[i] = 0;
      held_wet[0] = 0;
      held_wet[1] = 0;
    end
    c23 = tgt_reg[CFG_LPC_TGT][22:0];
    lp_t = c23;
    c23 = tgt_reg[CFG_HPC_TGT][22:0];
    hp_t = c23;
    c24 = tgt_reg[CFG_POSITION];
    pos_t = clip(c24, -L_ONE, L_ONE);
    wet_t = clip(longint'(tgt_reg[CFG_WET_AMT][22:0]), 0, L_ONE);
    pos_sm += qmul(pos_t - pos_sm, L_KPOS);
    wet_sm += qmul(wet_t - wet_sm, L_KWET);
    if (it.wet_present) begin
      held_wet[0] = wl;
      held_wet[1] = wr;
    end
    lpc_sm += qmul(lp_t - lpc_sm, L_KCOEF);
    hpc_sm += qmul(hp_t - hpc_sm, L_KCOEF);
    bypass = (pos_sm < L_BYPASS) && (pos_sm > -L_BYPASS);
    ol = filter_channel(held_wet[0], dl, 0, 2, bypass);
    orr = filter_channel(held_wet[1], dr, 1, 3, bypass);
    r.out_left = ol[23:0];
    r.out_right = orr[23:0];
    return r;
  endfunction

  function automatic in_item_t mk_req(logic [23:0] wl, logic [23:0] wr, bit pr,
                                      logic [23:0] dl, logic [23:0] dr, bit cl);
    in_item_t r;
    r.wet_left = wl;
    r.wet_right = wr;
    r.wet_present = pr;
    r.dry_left = dl;
    r.dry_right = dr;
    r.clear_history = cl;
    return r;
  endfunction

  function automatic void add_req(in_item_t r, bit typed, out_item_t w);
    dir_row_t row;
    row.is_wr = 1'b0;
    row.idx = CFG_LPC_TGT;
    row.val = '0;
    row.req = r;
    row.typed = typed;
    row.want = w;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_wr(cfg_idx_t idx, logic [23:0] val);
    dir_row_t row;
    row.is_wr = 1'b1;
    row.idx = idx;
    row.val = val;
    row.req = '0;
    row.typed = 1'b0;
    row.want = '0;
    dir_rows.push_back(row);
  endfunction

  // Extremes, zero, small values and full-range noise
  function automatic logic [23:0] rand_sample();
    int v;
    case ($urandom_range(0, 7))
      0: return S_MAX;
      1: return S_MIN;
      2: return '0;
      3: begin
        v = $urandom_range(0, 2000);
        v = v - 1000;
        return v[23:0];
      end
      default: return 24'($urandom());
    endcase
  endfunction

  function automatic in_item_t rand_req();
    in_item_t r;
    r.wet_left = rand_sample();
    r.wet_right = rand_sample();
    r.wet_present = ($urandom_range(0, 3) != 0);
    r.dry_left = rand_sample();
    r.dry_right = rand_sample();
    r.clear_history = ($urandom_range(0, 39) == 0);
    return r;
  endfunction

  // All driver tasks start and end just after a falling edge
  task automatic push_request(input in_item_t r, input bit typed, input out_item_t w);
    int base;
    base = req_taken;
    in_data = r;
    req_typed = typed;
    req_want = w;
    in_valid = 1'b1;
    do @(negedge clk); while (req_taken == base);
  endtask

  task automatic wait_mix_drained();
    in_valid = 1'b0;
    while (mix_pending.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [23:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    tgt_reg[idx] = (idx == CFG_POSITION) ? val : {1'b0, val[22:0]};
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Bursts of requests with random gaps, or back to back
  task automatic run_traffic(input int n, input bit gapped, input bit soak);
    in_item_t r;
    int       gap;
    for (int i = 0; i < n; i++) begin
      if (soak) begin
        // near-DC full-scale wet to drive the allpass states large
        r.wet_left = S_MAX - 24'($urandom_range(0, 255));
        r.wet_right = S_MIN + 24'($urandom_range(0, 255));
        r.wet_present = 1'($urandom_range(0, 1));
        r.dry_left = 24'($urandom());
        r.dry_right = 24'($urandom());
        r.clear_history = 1'b0;
      end else begin
        r = rand_req();
      end
      push_request(r, 1'b0, '0);
      if (gapped) begin
        burst_left--;
        if (burst_left <= 0) begin
          gap = $urandom_range(1, 45);
          in_valid = 1'b0;
          repeat (gap) @(negedge clk);
          burst_left = $urandom_range(1, 12);
        end
      end
    end
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Cycle limit
  initial cyc_count = 0;
  always @(posedge clk) begin
    cyc_count++;
    if (cyc_count > CYC_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Request side: predict on every accepted request
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      head_mix = compute_mix(in_data);
      mix_pending.push_back(req_typed ? req_want : head_mix);
      req_taken++;
    end
  end

  // Result side: compare against the oldest pending mix
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (mix_pending.size() == 0) begin
        $error("unexpected result: no request pending");
        fails++;
      end else begin
        head_mix = mix_pending.pop_front();
        if (out_data.out_left !== head_mix.out_left) begin
          $error("out_left mismatch: expected %0d, got %0d",
                 $signed(head_mix.out_left), $signed(out_data.out_left));
          fails++;
        end
        if (out_data.out_right !== head_mix.out_right) begin
          $error("out_right mismatch: expected %0d, got %0d",
                 $signed(head_mix.out_right), $signed(out_data.out_right));
          fails++;
        end
      end
    end
  end

  // Output backpressure: always ready, random, periodic and long stalls
  initial begin : rx_pattern
    int rx_cyc;
    int hold;
    out_ready = 1'b0;
    rx_cyc = 0;
    hold = 0;
    forever begin
      @(negedge clk);
      rx_cyc++;
      case ((rx_cyc / 900) % 4)
        0: out_ready = 1'b1;
        1: out_ready = ($urandom_range(0, 3) != 0);
        2: out_ready = ((rx_cyc % 29) >= 11);
        default: begin
          if (hold > 0) begin
            hold--;
            out_ready = 1'b0;
          end else if ($urandom_range(0, 5) == 0) begin
            hold = $urandom_range(1, 14);
            out_ready = 1'b0;
          end else begin
            out_ready = 1'b1;
          end
        end
      endcase
    end
  end

  // Stimulus
  initial begin : stim
    int          sent;
    int          n;
    int          v;
    logic [23:0] val;
    out_item_t   w;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    rst_n = 1'b0;
    req_typed = 1'b0;
    req_want = '0;
    req_taken = 0;
    fails = 0;
    burst_left = 1;

    tgt_reg[CFG_LPC_TGT] = {1'b0, LPC_TGT_RST};
    tgt_reg[CFG_HPC_TGT] = {1'b0, HPC_TGT_RST};
    tgt_reg[CFG_POSITION] = POSITION_RST;
    tgt_reg[CFG_WET_AMT] = {1'b0, WET_AMT_RST};
    pos_sm = 0;
    lpc_sm = 0;
    hpc_sm = 0;
    wet_sm = L_WETRST;
    held_wet[0] = 0;
    held_wet[1] = 0;
    for (int i = 0; i < 4; i++) ap_hist[i] = 0;

    // Directed part; position starts at center, so equal wet and dry pass through, clamped to plus or minus one
    w = '0;
    add_req(mk_req('0, '0, 1, '0, '0, 1), 1, w);
    w.out_left = P_ONE;
    w.out_right = P_ONE;
    add_req(mk_req(S_MAX, S_MAX, 1, S_MAX, S_MAX, 0), 1, w);
    w.out_left = N_ONE;
    w.out_right = N_ONE;
    add_req(mk_req(S_MIN, S_MIN, 1, S_MIN, S_MIN, 0), 1, w);
    w = '0;
    add_req(mk_req(S_MAX, S_MIN, 1, S_MIN, S_MAX, 0), 0, w);
    add_req(mk_req('0, '0, 0, 24'd12345, -24'sd12345, 0), 0, w);
    // leave center for one step, then return to it with live allpass states
    add_wr(CFG_POSITION, P_ONE);
    add_req(mk_req(S_MAX, S_MIN, 1, '0, '0, 0), 0, w);
    add_wr(CFG_POSITION, '0);
    add_req(mk_req(S_MIN, S_MAX, 0, S_MAX, S_MIN, 0), 0, w);
    // clear without fresh wet uses the zeroed held pair
    add_req(mk_req(24'h123456, 24'hABCDEF, 0, 24'h0F0F0F, 24'hF0F0F0, 1), 0, w);
    add_wr(CFG_LPC_TGT, 24'h3FFFFF);
    add_wr(CFG_HPC_TGT, 24'h400000);
    add_wr(CFG_POSITION, S_MAX);
    add_wr(CFG_WET_AMT, 24'h7FFFFF);
    add_req(mk_req(S_MAX, S_MIN, 1, S_MIN, S_MAX, 0), 0, w);
    add_req(mk_req(S_MIN, S_MAX, 1, S_MAX, S_MIN, 0), 0, w);
    add_wr(CFG_POSITION, S_MIN);
    add_wr(CFG_WET_AMT, '0);
    add_req(mk_req(S_MAX, S_MAX, 1, S_MIN, S_MIN, 0), 0, w);
    add_req(mk_req(24'hFFFFFF, 24'd1, 0, 24'hFFFFFF, 24'd1, 0), 0, w);
    add_wr(CFG_LPC_TGT, 24'h400000);
    add_wr(CFG_HPC_TGT, 24'h3FFFFF);
    add_wr(CFG_WET_AMT, P_ONE);
    add_req(mk_req(S_MAX, S_MIN, 1, '0, 24'hFFFFFF, 0), 0, w);
    add_req(mk_req('0, '0, 1, S_MAX, S_MIN, 1), 0, w);

    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_wr) begin
        wait_mix_drained();
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        push_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // Random phases, each with fresh position and wet settings and often new coefficient targets
    sent = 0;
    while (sent < RAND_REQS) begin
      n = $urandom_range(40, 150);
      wait_mix_drained();
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 3))
          0: val = 24'h3FFFFF;
          1: val = 24'h400000;
          2: val = 24'hC00000;
          default: val = 24'($urandom());
        endcase
        write_reg(CFG_LPC_TGT, val);
      end
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 3))
          0: val = 24'h3FFFFF;
          1: val = 24'h400000;
          2: val = 24'hC00000;
          default: val = 24'($urandom());
        endcase
        write_reg(CFG_HPC_TGT, val);
      end
      // position: extremes, out of range, near center, or anything
      case ($urandom_range(0, 5))
        0: begin
          case ($urandom_range(0, 3))
            0: val = P_ONE;
            1: val = N_ONE;
            2: val = S_MAX;
            default: val = S_MIN;
          endcase
        end
        1, 2: begin
          v = $urandom_range(0, 40000);
          v = v - 20000;
          val = v[23:0];
        end
        3: val = '0;
        default: val = 24'($urandom());
      endcase
      write_reg(CFG_POSITION, val);
      case ($urandom_range(0, 4))
        0: val = '0;
        1: val = P_ONE;
        2: val = 24'($urandom_range(24'h400001, 24'h7FFFFF));
        default: val = 24'($urandom());
      endcase
      write_reg(CFG_WET_AMT, val);
      run_traffic(n, $urandom_range(0, 3) != 0, 1'b0);
      sent += n;
    end

    // Soak with coefficients at the extremes and near-full-scale DC wet
    wait_mix_drained();
    write_reg(CFG_LPC_TGT, 24'h3FFFFF);
    write_reg(CFG_HPC_TGT, 24'h400000);
    write_reg(CFG_POSITION, P_ONE);
    write_reg(CFG_WET_AMT, 24'($urandom()));
    run_traffic(SOAK_REQS, 1'b0, 1'b1);

    // Swing the position through center so the built-up states decay
    wait_mix_drained();
    write_reg(CFG_POSITION, N_ONE);
    run_traffic(SWING_REQS, 1'b1, 1'b0);

    wait_mix_drained();
    repeat (60) @(negedge clk);
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
sv/sacfm_pkg.sv
sv/sacfm_mac.sv
sv/sacfm_ctrl.sv
sv/stereo_allpass_crossfade_filter_mix.sv
sv/sacfm_checker.sv
sim/stereo_allpass_crossfade_filter_mix_tb.sv
